/* design/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold on every clock outside reset
`define LBC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("lbc assertion failed");
// expression must never be true outside reset
`define LBC_NEVER(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("lbc forbidden condition");
`else
`define LBC_ASSERT(lbl, prop)
`define LBC_NEVER(lbl, expr)
`endif

`endif

/* design/lbc_pkg.sv */
`default_nettype none
package lbc_pkg;

    localparam int NUM_SLOTS   = 64;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
    localparam int ADDR_W      = 48;
    localparam int PIN_W       = 8;
    localparam int BLOCK_BYTES = 512;
    localparam int OFF_W       = $clog2(BLOCK_BYTES);
    localparam int RAM_W       = ADDR_W + PIN_W;
    localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        MODE_GET   = 2'd0,
        MODE_REL   = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_RSVD  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_HIT   = 2'd0,
        KIND_FETCH = 2'd1,
        KIND_WB    = 2'd2,
        KIND_DONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISALIGN = 2'd1,
        ST_PINNED   = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        SSRC_ZERO = 2'd0,
        SSRC_CUR  = 2'd1,
        SSRC_IN   = 2'd2,
        SSRC_USED = 2'd3
    } slot_src_t;

    typedef enum logic [1:0] {
        ASRC_ZERO = 2'd0,
        ASRC_IN   = 2'd1,
        ASRC_RD   = 2'd2
    } addr_src_t;

    typedef enum logic [2:0] {
        UPD_NONE  = 3'd0,
        UPD_HIT   = 3'd1,
        UPD_FILL  = 3'd2,
        UPD_FETCH = 3'd3,
        UPD_REL   = 3'd4,
        UPD_FLUSH = 3'd5
    } upd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_HIT_RD,
        S_HIT_CHK,
        S_FILL,
        S_VIC_RD,
        S_VIC_CHK,
        S_FETCH,
        S_REL_RD,
        S_REL_WR,
        S_FL_RD,
        S_FL_CHK
    } state_t;

    typedef struct packed {
        logic      latch;
        logic      pos_clr;
        logic      pos_inc;
        logic      rd_walk;
        logic      rd_in;
        upd_t      upd;
        logic      emit;
        kind_t     kind;
        stat_t     status;
        slot_src_t slot_src;
        addr_src_t addr_src;
        logic      last;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  misaligned;
        logic  full;
        logic  walk_end;
        logic  match;
        logic  pin_zero;
        logic  cur_dirty;
        logic  more_dirty;
        logic  out_free;
        cnt_t  used;
    } sts_t;

endpackage
`default_nettype wire

/* design/lbc_ram.sv */
`default_nettype none
module lbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* design/lbc_ctrl.sv */
`default_nettype none
module lbc_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output      logic          s_tready,
    input  wire lbc_pkg::sts_t sts,
    output      lbc_pkg::cmd_t cmd
);

    lbc_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lbc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lbc_pkg::S_IDLE: begin
                if (s_tvalid) state_next = lbc_pkg::S_DECODE;
            end
            lbc_pkg::S_DECODE: begin
                unique case (sts.mode)
                    lbc_pkg::MODE_GET: begin
                        if (!sts.misaligned) state_next = lbc_pkg::S_HIT_RD;
                        else if (sts.out_free) state_next = lbc_pkg::S_IDLE;
                    end
                    lbc_pkg::MODE_REL:   state_next = lbc_pkg::S_REL_RD;
                    lbc_pkg::MODE_FLUSH: state_next = lbc_pkg::S_FL_RD;
                    lbc_pkg::MODE_RSVD: begin
                        if (sts.out_free) state_next = lbc_pkg::S_IDLE;
                    end
                endcase
            end
            lbc_pkg::S_HIT_RD: begin
                if (!sts.walk_end) state_next = lbc_pkg::S_HIT_CHK;
                else if (sts.full) state_next = lbc_pkg::S_VIC_RD;
                else state_next = lbc_pkg::S_FILL;
            end
            lbc_pkg::S_HIT_CHK: begin
                if (!sts.match) state_next = lbc_pkg::S_HIT_RD;
                else if (sts.out_free) state_next = lbc_pkg::S_IDLE;
            end
            lbc_pkg::S_FILL: begin
                if (sts.out_free) state_next = lbc_pkg::S_IDLE;
            end
            lbc_pkg::S_VIC_RD: begin
                if (!sts.walk_end) state_next = lbc_pkg::S_VIC_CHK;
                else if (sts.out_free) state_next = lbc_pkg::S_IDLE;
            end
            lbc_pkg::S_VIC_CHK: begin
                if (!sts.pin_zero) state_next = lbc_pkg::S_VIC_RD;
                else if (!sts.cur_dirty || sts.out_free) state_next = lbc_pkg::S_FETCH;
            end
            lbc_pkg::S_FETCH: begin
                if (sts.out_free) state_next = lbc_pkg::S_IDLE;
            end
            lbc_pkg::S_REL_RD: state_next = lbc_pkg::S_REL_WR;
            lbc_pkg::S_REL_WR: begin
                if (sts.out_free) state_next = lbc_pkg::S_IDLE;
            end
            lbc_pkg::S_FL_RD: begin
                if (!sts.walk_end) state_next = lbc_pkg::S_FL_CHK;
                else if (sts.out_free) state_next = lbc_pkg::S_IDLE;
            end
            lbc_pkg::S_FL_CHK: begin
                if (!sts.cur_dirty) state_next = lbc_pkg::S_FL_RD;
                else if (sts.out_free) begin
                    state_next = sts.more_dirty ? lbc_pkg::S_FL_RD : lbc_pkg::S_IDLE;
                end
            end
            default: state_next = lbc_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        s_tready     = 1'b0;
        cmd.latch    = 1'b0;
        cmd.pos_clr  = 1'b0;
        cmd.pos_inc  = 1'b0;
        cmd.rd_walk  = 1'b0;
        cmd.rd_in    = 1'b0;
        cmd.upd      = lbc_pkg::UPD_NONE;
        cmd.emit     = 1'b0;
        cmd.kind     = lbc_pkg::KIND_DONE;
        cmd.status   = lbc_pkg::ST_OK;
        cmd.slot_src = lbc_pkg::SSRC_ZERO;
        cmd.addr_src = lbc_pkg::ASRC_ZERO;
        cmd.last     = 1'b1;
        unique case (state_reg)
            lbc_pkg::S_IDLE: begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            lbc_pkg::S_DECODE: begin
                unique case (sts.mode)
                    lbc_pkg::MODE_GET: begin
                        if (!sts.misaligned) begin
                            cmd.pos_clr = 1'b1;
                        end else begin
                            cmd.emit   = sts.out_free;
                            cmd.status = lbc_pkg::ST_MISALIGN;
                        end
                    end
                    lbc_pkg::MODE_REL:   cmd.pos_clr = 1'b0;
                    lbc_pkg::MODE_FLUSH: cmd.pos_clr = 1'b1;
                    lbc_pkg::MODE_RSVD:  cmd.emit = sts.out_free;
                endcase
            end
            lbc_pkg::S_HIT_RD: begin
                if (!sts.walk_end) cmd.rd_walk = 1'b1;
                else cmd.pos_clr = 1'b1;
            end
            lbc_pkg::S_HIT_CHK: begin
                if (!sts.match) begin
                    cmd.pos_inc = 1'b1;
                end else if (sts.out_free) begin
                    cmd.upd      = lbc_pkg::UPD_HIT;
                    cmd.emit     = 1'b1;
                    cmd.kind     = lbc_pkg::KIND_HIT;
                    cmd.slot_src = lbc_pkg::SSRC_CUR;
                    cmd.addr_src = lbc_pkg::ASRC_IN;
                end
            end
            lbc_pkg::S_FILL: begin
                if (sts.out_free) begin
                    cmd.upd      = lbc_pkg::UPD_FILL;
                    cmd.emit     = 1'b1;
                    cmd.kind     = lbc_pkg::KIND_FETCH;
                    cmd.slot_src = lbc_pkg::SSRC_USED;
                    cmd.addr_src = lbc_pkg::ASRC_IN;
                end
            end
            lbc_pkg::S_VIC_RD: begin
                if (!sts.walk_end) begin
                    cmd.rd_walk = 1'b1;
                end else begin
                    cmd.emit   = sts.out_free;
                    cmd.status = lbc_pkg::ST_PINNED;
                end
            end
            lbc_pkg::S_VIC_CHK: begin
                if (!sts.pin_zero) begin
                    cmd.pos_inc = 1'b1;
                end else if (sts.cur_dirty) begin
                    cmd.emit     = sts.out_free;
                    cmd.kind     = lbc_pkg::KIND_WB;
                    cmd.slot_src = lbc_pkg::SSRC_CUR;
                    cmd.addr_src = lbc_pkg::ASRC_RD;
                    cmd.last     = 1'b0;
                end
            end
            lbc_pkg::S_FETCH: begin
                if (sts.out_free) begin
                    cmd.upd      = lbc_pkg::UPD_FETCH;
                    cmd.emit     = 1'b1;
                    cmd.kind     = lbc_pkg::KIND_FETCH;
                    cmd.slot_src = lbc_pkg::SSRC_CUR;
                    cmd.addr_src = lbc_pkg::ASRC_IN;
                end
            end
            lbc_pkg::S_REL_RD: cmd.rd_in = 1'b1;
            lbc_pkg::S_REL_WR: begin
                if (sts.out_free) begin
                    cmd.upd      = lbc_pkg::UPD_REL;
                    cmd.emit     = 1'b1;
                    cmd.slot_src = lbc_pkg::SSRC_IN;
                end
            end
            lbc_pkg::S_FL_RD: begin
                if (!sts.walk_end) cmd.rd_walk = 1'b1;
                else cmd.emit = sts.out_free;
            end
            lbc_pkg::S_FL_CHK: begin
                if (!sts.cur_dirty) begin
                    cmd.pos_inc = 1'b1;
                end else if (sts.out_free) begin
                    cmd.upd      = lbc_pkg::UPD_FLUSH;
                    cmd.emit     = 1'b1;
                    cmd.kind     = lbc_pkg::KIND_WB;
                    cmd.slot_src = lbc_pkg::SSRC_CUR;
                    cmd.addr_src = lbc_pkg::ASRC_RD;
                    cmd.last     = !sts.more_dirty;
                    cmd.pos_inc  = sts.more_dirty;
                end
            end
            default: s_tready = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

/* design/lbc_dp.sv */
`default_nettype none
module lbc_dp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [1:0]    s_tuser,
    input  wire logic [55:0]   s_tdata,
    input  wire lbc_pkg::cmd_t cmd,
    output      lbc_pkg::sts_t sts,
    output      logic          m_tvalid,
    input  wire logic          m_tready,
    output      logic [55:0]   m_tdata,
    output      logic [1:0]    m_tuser,
    output      logic          m_tlast
);

    // latched request
    lbc_pkg::mode_t mode_reg;
    lbc_pkg::addr_t addr_reg;
    lbc_pkg::slot_t slot_in_reg;
    logic           mark_reg;

    // walk and slot bookkeeping
    lbc_pkg::cnt_t  pos_reg, pos_next;
    lbc_pkg::cnt_t  used_reg;
    lbc_pkg::slot_t cur_reg;
    lbc_pkg::slot_t rank_reg [lbc_pkg::NUM_SLOTS];
    logic [lbc_pkg::NUM_SLOTS-1:0] dirty_reg;

    // output register
    logic                 m_valid_reg;
    lbc_pkg::kind_t       m_kind_reg;
    lbc_pkg::stat_t       m_stat_reg;
    lbc_pkg::slot_t       m_slot_reg;
    lbc_pkg::addr_t       m_addr_reg;
    logic                 m_last_reg;

    lbc_pkg::slot_t             walk_slot;
    lbc_pkg::slot_t             rd_slot;
    logic                       ram_re, ram_we;
    lbc_pkg::slot_t             ram_waddr;
    logic [lbc_pkg::RAM_W-1:0]  ram_wdata, ram_rdata;
    lbc_pkg::addr_t             rd_addr;
    logic [lbc_pkg::PIN_W-1:0]  rd_pins, pins_inc, pins_dec;
    logic                       rel_valid;
    logic                       more_dirty;
    logic                       out_free;
    lbc_pkg::slot_t             used_slot, last_rank;

    assign used_slot = used_reg[lbc_pkg::SLOT_W-1:0];
    assign last_rank = lbc_pkg::SLOT_W'(used_reg - 1'b1);
    assign rd_addr   = ram_rdata[lbc_pkg::RAM_W-1:lbc_pkg::PIN_W];
    assign rd_pins   = ram_rdata[lbc_pkg::PIN_W-1:0];
    assign pins_inc  = (rd_pins == lbc_pkg::PIN_MAX) ? rd_pins : rd_pins + 1'b1;
    assign pins_dec  = (rd_pins == '0) ? rd_pins : rd_pins - 1'b1;
    assign rel_valid = {1'b0, slot_in_reg} < used_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            mode_reg    <= lbc_pkg::mode_t'(s_tuser);
            addr_reg    <= s_tdata[lbc_pkg::ADDR_W-1:0];
            slot_in_reg <= s_tdata[lbc_pkg::ADDR_W +: lbc_pkg::SLOT_W];
            mark_reg    <= s_tdata[lbc_pkg::ADDR_W + lbc_pkg::SLOT_W];
        end
    end

    // slot holding the walk position in recency order
    always_comb begin
        walk_slot = '0;
        for (int i = 0; i < lbc_pkg::NUM_SLOTS; i++) begin
            if (lbc_pkg::CNT_W'(i) < used_reg &&
                rank_reg[i] == pos_reg[lbc_pkg::SLOT_W-1:0]) begin
                walk_slot = lbc_pkg::SLOT_W'(i);
            end
        end
    end

    // any dirty slot more recent than the walk position
    always_comb begin
        more_dirty = 1'b0;
        for (int i = 0; i < lbc_pkg::NUM_SLOTS; i++) begin
            if (lbc_pkg::CNT_W'(i) < used_reg && dirty_reg[i] &&
                {1'b0, rank_reg[i]} > pos_reg) begin
                more_dirty = 1'b1;
            end
        end
    end

    // walk position
    always_comb begin
        pos_next = pos_reg;
        if (cmd.pos_clr) pos_next = '0;
        else if (cmd.pos_inc) pos_next = pos_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // slot under read
    assign ram_re  = cmd.rd_walk || cmd.rd_in;
    assign rd_slot = cmd.rd_walk ? walk_slot : slot_in_reg;

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            cur_reg <= rd_slot;
        end
    end

    // address and pin count store writes
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = {rd_addr, pins_inc};
        unique case (cmd.upd)
            lbc_pkg::UPD_HIT: ram_we = 1'b1;
            lbc_pkg::UPD_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = used_slot;
                ram_wdata = {addr_reg, lbc_pkg::PIN_W'(1)};
            end
            lbc_pkg::UPD_FETCH: begin
                ram_we    = 1'b1;
                ram_wdata = {addr_reg, lbc_pkg::PIN_W'(1)};
            end
            lbc_pkg::UPD_REL: begin
                ram_we    = rel_valid;
                ram_waddr = slot_in_reg;
                ram_wdata = {rd_addr, pins_dec};
            end
            lbc_pkg::UPD_NONE, lbc_pkg::UPD_FLUSH: ram_we = 1'b0;
            default: ram_we = 1'b0;
        endcase
    end

    lbc_ram #(
        .WIDTH(lbc_pkg::RAM_W),
        .DEPTH(lbc_pkg::NUM_SLOTS)
    ) u_store (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(rd_slot),
        .rdata(ram_rdata)
    );

    // recency ranks
    always_ff @(posedge aclk) begin
        for (int i = 0; i < lbc_pkg::NUM_SLOTS; i++) begin
            if (cmd.upd == lbc_pkg::UPD_HIT || cmd.upd == lbc_pkg::UPD_FETCH) begin
                if (lbc_pkg::CNT_W'(i) < used_reg) begin
                    if (cur_reg == lbc_pkg::SLOT_W'(i)) begin
                        rank_reg[i] <= last_rank;
                    end else if ({1'b0, rank_reg[i]} > pos_reg) begin
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                    end
                end
            end else if (cmd.upd == lbc_pkg::UPD_FILL && used_slot == lbc_pkg::SLOT_W'(i)) begin
                rank_reg[i] <= used_slot;
            end
        end
    end

    // dirty marks and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg <= '0;
            used_reg  <= '0;
        end else begin
            unique case (cmd.upd)
                lbc_pkg::UPD_FILL: begin
                    dirty_reg[used_slot] <= 1'b0;
                    used_reg             <= used_reg + 1'b1;
                end
                lbc_pkg::UPD_FETCH, lbc_pkg::UPD_FLUSH: dirty_reg[cur_reg] <= 1'b0;
                lbc_pkg::UPD_REL: begin
                    if (rel_valid && mark_reg) dirty_reg[slot_in_reg] <= 1'b1;
                end
                lbc_pkg::UPD_NONE, lbc_pkg::UPD_HIT: used_reg <= used_reg;
                default: used_reg <= used_reg;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_kind_reg <= cmd.kind;
            m_stat_reg <= cmd.status;
            m_last_reg <= cmd.last;
            unique case (cmd.slot_src)
                lbc_pkg::SSRC_ZERO: m_slot_reg <= '0;
                lbc_pkg::SSRC_CUR:  m_slot_reg <= cur_reg;
                lbc_pkg::SSRC_IN:   m_slot_reg <= slot_in_reg;
                lbc_pkg::SSRC_USED: m_slot_reg <= used_slot;
            endcase
            unique case (cmd.addr_src)
                lbc_pkg::ASRC_IN: m_addr_reg <= addr_reg;
                lbc_pkg::ASRC_RD: m_addr_reg <= rd_addr;
                default:          m_addr_reg <= '0;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {m_addr_reg, m_slot_reg, m_stat_reg};

    // status back to the controller
    assign sts.mode       = mode_reg;
    assign sts.misaligned = addr_reg[lbc_pkg::OFF_W-1:0] != '0;
    assign sts.full       = used_reg == lbc_pkg::CNT_W'(lbc_pkg::NUM_SLOTS);
    assign sts.walk_end   = pos_reg >= used_reg;
    assign sts.match      = rd_addr == addr_reg;
    assign sts.pin_zero   = rd_pins == '0;
    assign sts.cur_dirty  = dirty_reg[cur_reg];
    assign sts.more_dirty = more_dirty;
    assign sts.out_free   = out_free;
    assign sts.used       = used_reg;

endmodule
`default_nettype wire

/* design/lru_block_cache_controller.sv */
// gets walk slots in recency order, least recent first, looking for a hit, then fill a
// free slot or walk again for the least recent unpinned victim (writeback if dirty,
// then fetch; status pinned if every slot is pinned); flush walks for dirty slots.
// one item at a time: the next beat is taken once the controller is back in idle,
// after its final result is registered. sync reset empties the cache.
`default_nettype none
`include "assert_macros.svh"
module lru_block_cache_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [55:0] s_tdata,  // byte_address, slot, mark_dirty, pad
    input  wire logic [1:0]  s_tuser,  // mode
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [55:0] m_tdata,  // status, slot_index, address
    output      logic [1:0]  m_tuser,  // kind
    output      logic        m_tlast
);

    lbc_pkg::cmd_t cmd;
    lbc_pkg::sts_t sts;

    lbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lbc_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // checks
    `LBC_NEVER(a_used_range, sts.used > lbc_pkg::CNT_W'(lbc_pkg::NUM_SLOTS))
    `LBC_ASSERT(a_emit_free, cmd.emit |-> sts.out_free)
    `LBC_ASSERT(a_fill_room, cmd.upd == lbc_pkg::UPD_FILL |-> !sts.full)

endmodule
`default_nettype wire

/* tb/lbc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// watches both channels, models the cache and compares every result beat
module lbc_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [55:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending
);

    typedef struct {
        lbc_pkg::kind_t kind;
        lbc_pkg::stat_t status;
        lbc_pkg::slot_t slot_index;
        lbc_pkg::addr_t address;
        logic           last;
    } cache_result_t;

    // model state
    logic                      line_valid [lbc_pkg::NUM_SLOTS];
    lbc_pkg::addr_t            line_addr  [lbc_pkg::NUM_SLOTS];
    logic                      line_dirty [lbc_pkg::NUM_SLOTS];
    logic [lbc_pkg::PIN_W-1:0] line_pins  [lbc_pkg::NUM_SLOTS];
    lbc_pkg::slot_t            lru_order  [lbc_pkg::NUM_SLOTS];
    int                        lines_used;
    cache_result_t             awaited_results [$];
    int                        mismatches;

    function automatic void push_result(lbc_pkg::kind_t k, lbc_pkg::stat_t st,
                                        lbc_pkg::slot_t sl, lbc_pkg::addr_t a, logic l);
        cache_result_t r;
        r.kind = k;
        r.status = st;
        r.slot_index = sl;
        r.address = a;
        r.last = l;
        awaited_results.push_back(r);
    endfunction

    // move recency position pos to the most recent end
    function automatic void touch_lru(int pos);
        lbc_pkg::slot_t s;
        s = lru_order[pos];
        for (int i = pos; i + 1 < lines_used; i++) lru_order[i] = lru_order[i + 1];
        lru_order[lines_used - 1] = s;
    endfunction

    function automatic void lookup_block(lbc_pkg::addr_t a);
        int             i;
        lbc_pkg::slot_t s;
        if (a[lbc_pkg::OFF_W-1:0] != '0) begin
            push_result(lbc_pkg::KIND_DONE, lbc_pkg::ST_MISALIGN, '0, '0, 1'b1);
            return;
        end
        for (i = 0; i < lines_used; i++) begin
            s = lru_order[i];
            if (line_valid[s] && line_addr[s] == a) begin
                if (line_pins[s] != lbc_pkg::PIN_MAX) line_pins[s]++;
                touch_lru(i);
                push_result(lbc_pkg::KIND_HIT, lbc_pkg::ST_OK, s, a, 1'b1);
                return;
            end
        end
        // free slot fills in order
        if (lines_used < lbc_pkg::NUM_SLOTS) begin
            s = lbc_pkg::slot_t'(lines_used);
            line_valid[s] = 1'b1;
            line_addr[s] = a;
            line_dirty[s] = 1'b0;
            line_pins[s] = lbc_pkg::PIN_W'(1);
            lru_order[lines_used] = s;
            lines_used++;
            push_result(lbc_pkg::KIND_FETCH, lbc_pkg::ST_OK, s, a, 1'b1);
            return;
        end
        // victim is least recent unpinned line
        for (i = 0; i < lines_used; i++) begin
            s = lru_order[i];
            if (line_pins[s] == 0) break;
        end
        if (i >= lines_used) begin
            push_result(lbc_pkg::KIND_DONE, lbc_pkg::ST_PINNED, '0, '0, 1'b1);
            return;
        end
        if (line_dirty[s])
            push_result(lbc_pkg::KIND_WB, lbc_pkg::ST_OK, s, line_addr[s], 1'b0);
        line_addr[s] = a;
        line_dirty[s] = 1'b0;
        line_pins[s] = lbc_pkg::PIN_W'(1);
        touch_lru(i);
        push_result(lbc_pkg::KIND_FETCH, lbc_pkg::ST_OK, s, a, 1'b1);
    endfunction

    function automatic void cache_predict(lbc_pkg::mode_t mode, lbc_pkg::addr_t a,
                                          lbc_pkg::slot_t sl, logic md);
        int             n;
        lbc_pkg::slot_t s;
        case (mode)
            lbc_pkg::MODE_GET: lookup_block(a);
            lbc_pkg::MODE_REL: begin
                if (line_valid[sl]) begin
                    if (line_pins[sl] != 0) line_pins[sl]--;
                    if (md) line_dirty[sl] = 1'b1;
                end
                push_result(lbc_pkg::KIND_DONE, lbc_pkg::ST_OK, sl, '0, 1'b1);
            end
            lbc_pkg::MODE_FLUSH: begin
                n = 0;
                for (int i = 0; i < lines_used && n < lbc_pkg::NUM_SLOTS; i++) begin
                    s = lru_order[i];
                    if (line_valid[s] && line_dirty[s]) begin
                        push_result(lbc_pkg::KIND_WB, lbc_pkg::ST_OK, s, line_addr[s], 1'b0);
                        line_dirty[s] = 1'b0;
                        n++;
                    end
                end
                if (n == 0) push_result(lbc_pkg::KIND_DONE, lbc_pkg::ST_OK, '0, '0, 1'b1);
                else awaited_results[$].last = 1'b1;
            end
            default: push_result(lbc_pkg::KIND_DONE, lbc_pkg::ST_OK, '0, '0, 1'b1);
        endcase
    endfunction

    always @(posedge aclk) begin
        cache_result_t exp_r;
        if (!aresetn) begin
            for (int i = 0; i < lbc_pkg::NUM_SLOTS; i++) begin
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_pins[i] = '0;
            end
            lines_used = 0;
            awaited_results.delete();
            fail_count <= 0;
            pending <= 0;
            mismatches = 0;
        end else begin
            // input beat
            if (s_tvalid && s_tready)
                cache_predict(lbc_pkg::mode_t'(s_tuser), s_tdata[47:0], s_tdata[53:48],
                              s_tdata[54]);
            // result beat
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: kind %0d status %0d slot %0d addr %h",
                                 m_tuser, m_tdata[1:0], m_tdata[7:2], m_tdata[55:8]);
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (m_tuser != exp_r.kind || m_tdata[1:0] != exp_r.status ||
                        m_tdata[7:2] != exp_r.slot_index || m_tdata[55:8] != exp_r.address ||
                        m_tlast != exp_r.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected kind %0d status %0d slot %0d",
                                     exp_r.kind, exp_r.status, exp_r.slot_index,
                                     " addr %h last %0d", exp_r.address, exp_r.last);
                            $display("          got kind %0d status %0d slot %0d",
                                     m_tuser, m_tdata[1:0], m_tdata[7:2],
                                     " addr %h last %0d", m_tdata[55:8], m_tlast);
                        end
                    end
                end
            end
            fail_count <= mismatches;
            pending <= awaited_results.size();
        end
    end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [55:0]    s_tdata;
    logic [1:0]     s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [55:0]    m_tdata;
    logic [1:0]     m_tuser;
    logic           m_tlast;
    int             fail_count;
    int             pending;
    int             tx_idle;
    int             rx_idle;
    logic           rx_hold;
    lbc_pkg::addr_t block_pool [96];

    lru_block_cache_controller dut (.*);

    lbc_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (rx_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= rx_idle);
    end

    // one input beat, with random gaps ahead of it
    task automatic send_beat(lbc_pkg::mode_t mode, lbc_pkg::addr_t a, lbc_pkg::slot_t sl,
                             logic md);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {1'b0, md, sl, a};
        do @(posedge aclk); while (!s_tready);
    endtask

    // mostly pool gets and releases, some noise
    task automatic random_beat();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            send_beat(lbc_pkg::MODE_GET, block_pool[$urandom_range(95)], '0, 1'($urandom));
        else if (pick < 55)
            send_beat(lbc_pkg::MODE_GET, lbc_pkg::addr_t'({$urandom, $urandom}),
                      6'($urandom), 1'($urandom));
        else if (pick < 88)
            send_beat(lbc_pkg::MODE_REL, lbc_pkg::addr_t'({$urandom, $urandom}),
                      6'($urandom), 1'($urandom));
        else if (pick < 96)
            send_beat(lbc_pkg::MODE_FLUSH, '0, '0, 1'b0);
        else
            send_beat(lbc_pkg::MODE_RSVD, lbc_pkg::addr_t'({$urandom, $urandom}),
                      6'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = lbc_pkg::MODE_GET;
        rx_hold = 1'b0;
        tx_idle = 0;
        rx_idle = 0;
        for (int i = 0; i < 96; i++)
            block_pool[i] = {39'({$urandom, $urandom}), 9'b0};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        send_beat(lbc_pkg::MODE_GET, '0, '0, 1'b0);
        send_beat(lbc_pkg::MODE_GET, 48'hFFFF_FFFF_FE00, 6'h3F, 1'b1);
        send_beat(lbc_pkg::MODE_GET, 48'h1, '0, 1'b0);
        send_beat(lbc_pkg::MODE_GET, 48'hFFFF_FFFF_FFFF, '0, 1'b0);
        send_beat(lbc_pkg::MODE_GET, 48'h100, '0, 1'b0);
        send_beat(lbc_pkg::MODE_GET, '0, '0, 1'b0);
        send_beat(lbc_pkg::MODE_REL, '0, 6'd0, 1'b1);
        send_beat(lbc_pkg::MODE_REL, '0, 6'd0, 1'b0);
        send_beat(lbc_pkg::MODE_REL, '0, 6'd0, 1'b0);
        send_beat(lbc_pkg::MODE_REL, '0, 6'd63, 1'b1);
        send_beat(lbc_pkg::MODE_REL, 48'hFFFF_FFFF_FFFF, 6'd1, 1'b1);
        send_beat(lbc_pkg::MODE_FLUSH, '0, '0, 1'b0);
        send_beat(lbc_pkg::MODE_FLUSH, '0, '0, 1'b0);
        send_beat(lbc_pkg::MODE_RSVD, 48'hFFFF_FFFF_FFFF, 6'h3F, 1'b1);

        // pin saturation on one block
        for (int i = 0; i < 257; i++) send_beat(lbc_pkg::MODE_GET, 48'h200, '0, 1'b0);

        // fill every slot, then a get that has to search for a victim
        for (int i = 0; i < 62; i++) send_beat(lbc_pkg::MODE_GET, block_pool[i], '0, 1'b0);
        send_beat(lbc_pkg::MODE_GET, block_pool[95], '0, 1'b0);
        for (int i = 2; i < 18; i++) send_beat(lbc_pkg::MODE_REL, '0, 6'(i), 1'($urandom));

        // sender dense, receiver busy
        tx_idle = 11;
        rx_idle = 48;
        for (int i = 0; i < 10; i++) random_beat();
        send_beat(lbc_pkg::MODE_FLUSH, '0, '0, 1'b0);
        // swapped
        tx_idle = 48;
        rx_idle = 11;
        for (int i = 0; i < 10; i++) random_beat();
        // no idling, with a long receiver hold that backs up the input
        tx_idle = 0;
        rx_idle = 0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (600) @(posedge aclk);
                rx_hold = 1'b0;
            end
            for (int i = 0; i < 10; i++) random_beat();
        join
        send_beat(lbc_pkg::MODE_FLUSH, '0, '0, 1'b0);
        s_tvalid <= 1'b0;

        drain();
        if (fail_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
